>>> rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, constants and helper functions of the 3x3 RGB box blur core.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

  // Frame limits and register reset values
  localparam int MAX_WIDTH_DEF      = 1024;
  localparam int MAX_HEIGHT_DEF     = 4096;
  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int ROW_OUT_W  = 12;
  localparam int COL_OUT_W  = 10;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_FLD_W  = RGB_W + ROW_OUT_W + COL_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_FLD_W;

  // Rounded mean: q = ((2*sum + n) * recip(n)) >> RECIP_SHIFT
  localparam int SUM_W       = 12;
  localparam int DIVX_W      = SUM_W + 1;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int CNT_W       = 2;
  localparam int NCELL_W     = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SUM,
    ST_MUL,
    ST_PUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take;      // latch pixel, read line buffers, advance position
    logic step;      // shift window, write line buffers
    logic sum_load;  // load neighborhood sums for the selected result
    logic mul_load;  // load quotients
    logic out_load;  // load output register
    logic rs;        // 0: row r-1, 1: row r
    logic cs;        // 0: column c-1, 1: column c
    logic last;      // final result of this pixel
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_r0;    // row r-1 exists
    logic has_r1;    // r is the bottom row
    logic has_c0;    // column c-1 exists
    logic has_c1;    // c is the rightmost column
    logic out_free;  // output register can take a beat
  } sts_t;

  // Number of in-frame cells from row and column counts (each 1..3)
  function automatic logic [NCELL_W-1:0] cell_count(input logic [CNT_W-1:0] rc,
                                                    input logic [CNT_W-1:0] cc);
    logic [NCELL_W-1:0] n;
    n = NCELL_W'(rc) * NCELL_W'(cc);
    return n;
  endfunction

  // ceil(2^RECIP_SHIFT / (2*n)), exact for 2*sum+n below 2^13
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] rc,
                                               input logic [CNT_W-1:0] cc);
    logic [RECIP_W-1:0] m;
    case ({rc, cc}) inside
      4'b0101:                   m = 18'd131072;
      4'b0110, 4'b1001:          m = 18'd65536;
      4'b0111, 4'b1101:          m = 18'd43691;
      4'b1010:                   m = 18'd32768;
      4'b1011, 4'b1110:          m = 18'd21846;
      4'b1111:                   m = 18'd14564;
      default:                   m = 18'd131072;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bb3_ctrl.sv
// ----------------------------------------------------------------------------
// bb3_ctrl
// Sequencer: accepts one pixel, updates the window, then walks the 0 to 4
// results of that pixel through sum, multiply and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bb3_pkg::sts_t sts,
  output bb3_pkg::cmd_t      cmd
);

  bb3_pkg::state_t state_r, state_nxt;
  logic rs_r, rs_nxt;
  logic cs_r, cs_nxt;
  logic more_col, more_row;

  assign more_col = !cs_r && sts.has_c1;
  assign more_row = !rs_r && sts.has_r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bb3_pkg::ST_IDLE;
      rs_r    <= 1'b0;
      cs_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rs_r    <= rs_nxt;
      cs_r    <= cs_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    rs_nxt       = rs_r;
    cs_nxt       = cs_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.rs       = rs_r;
    cmd.cs       = cs_r;
    cmd.last     = !more_col && !more_row;
    unique case (state_r)
      bb3_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = bb3_pkg::ST_STEP;
        end
      end
      bb3_pkg::ST_STEP: begin
        cmd.step = 1'b1;
        if ((sts.has_r0 || sts.has_r1) && (sts.has_c0 || sts.has_c1)) begin
          rs_nxt    = !sts.has_r0;
          cs_nxt    = !sts.has_c0;
          state_nxt = bb3_pkg::ST_SUM;
        end else begin
          state_nxt = bb3_pkg::ST_IDLE;
        end
      end
      bb3_pkg::ST_SUM: begin
        cmd.sum_load = 1'b1;
        state_nxt    = bb3_pkg::ST_MUL;
      end
      bb3_pkg::ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = bb3_pkg::ST_PUT;
      end
      bb3_pkg::ST_PUT: begin
        // hold until the output register frees up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (more_col) begin
            cs_nxt    = 1'b1;
            state_nxt = bb3_pkg::ST_SUM;
          end else if (more_row) begin
            rs_nxt    = 1'b1;
            cs_nxt    = !sts.has_c0;
            state_nxt = bb3_pkg::ST_SUM;
          end else begin
            state_nxt = bb3_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = bb3_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/bb3_dpath.sv
// ----------------------------------------------------------------------------
// bb3_dpath
// Datapath: raster position counters, two line buffers in one memory, the
// 3x3 window, masked neighborhood sums, reciprocal multiply and output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_dpath #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF,
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           restart,
  input  wire logic [CW-1:0]                  w_last,
  input  wire logic [RW-1:0]                  h_last,
  input  wire logic [bb3_pkg::IN_TDATA_W-1:0] in_data,
  input  wire bb3_pkg::cmd_t                  cmd,
  output bb3_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [bb3_pkg::OUT_TDATA_W-1:0]     out_data,
  output logic                                out_last,
  output logic                                out_eof
);

  localparam int P  = bb3_pkg::PIX_W;
  localparam int LW = 2 * bb3_pkg::RGB_W;

  // position of the next pixel
  logic [RW-1:0] row_cnt_r;
  logic [CW-1:0] col_cnt_r;
  // position of the pixel in work
  logic [RW-1:0] pos_r_r;
  logic [CW-1:0] pos_c_r;
  logic [bb3_pkg::RGB_W-1:0] px_r;

  // line buffers: upper row in the high half, middle row in the low half
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] line_rd_r;

  logic [bb3_pkg::RGB_W-1:0] win_r [9];

  // sum stage
  logic [bb3_pkg::DIVX_W-1:0]  x_r [3];
  logic [bb3_pkg::RECIP_W-1:0] recip_r;
  logic [RW-1:0]               orow_r;
  logic [CW-1:0]               ocol_r;
  logic                        eof_r;
  logic                        last_r;

  // multiply stage
  logic [P-1:0] q_r [3];

  // output register
  logic                           out_valid_r;
  logic [P-1:0]                   out_col_r [3];
  logic [bb3_pkg::ROW_OUT_W-1:0]  out_row_r;
  logic [bb3_pkg::COL_OUT_W-1:0]  out_cl_r;
  logic                           out_last_r;
  logic                           out_eof_r;

  logic [2:0] row_mask, col_mask;
  logic [bb3_pkg::CNT_W-1:0] rc, cc;
  logic [bb3_pkg::NCELL_W-1:0] ncell;
  logic [bb3_pkg::SUM_W-1:0] sum [3];
  logic [RW-1:0] orow;
  logic [CW-1:0] ocol;
  logic [bb3_pkg::DIVX_W+bb3_pkg::RECIP_W-1:0] prod [3];

  assign sts.has_r0   = (pos_r_r != '0);
  assign sts.has_r1   = (pos_r_r == h_last);
  assign sts.has_c0   = (pos_c_r != '0);
  assign sts.has_c1   = (pos_c_r == w_last);
  assign sts.out_free = !out_valid_r || out_ready;

  // position counters
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (cmd.take) begin
      if (col_cnt_r == w_last) begin
        col_cnt_r <= '0;
        row_cnt_r <= (row_cnt_r == h_last) ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_r <= col_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pos_r_r <= row_cnt_r;
      pos_c_r <= col_cnt_r;
      px_r    <= in_data;
    end
  end

  // line buffer memory: read at accept, write back during the step
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      line_mem[pos_c_r] <= {line_rd_r[bb3_pkg::RGB_W-1:0], px_r};
    end
    if (cmd.take) begin
      line_rd_r <= line_mem[col_cnt_r];
    end
  end

  // window: column 2 is the newest
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i*3]   <= win_r[i*3+1];
        win_r[i*3+1] <= win_r[i*3+2];
      end
      win_r[2] <= line_rd_r[LW-1:bb3_pkg::RGB_W];
      win_r[5] <= line_rd_r[bb3_pkg::RGB_W-1:0];
      win_r[8] <= px_r;
    end
  end

  // in-frame window rows and columns for the selected result
  always_comb begin
    row_mask[0] = !cmd.rs && (pos_r_r != '0) && (pos_r_r != RW'(1));
    row_mask[1] = (pos_r_r != '0);
    row_mask[2] = 1'b1;
    col_mask[0] = !cmd.cs && (pos_c_r != '0) && (pos_c_r != CW'(1));
    col_mask[1] = (pos_c_r != '0);
    col_mask[2] = 1'b1;
    rc    = bb3_pkg::CNT_W'(row_mask[0]) + bb3_pkg::CNT_W'(row_mask[1])
          + bb3_pkg::CNT_W'(1);
    cc    = bb3_pkg::CNT_W'(col_mask[0]) + bb3_pkg::CNT_W'(col_mask[1])
          + bb3_pkg::CNT_W'(1);
    ncell = bb3_pkg::cell_count(rc, cc);
    orow  = cmd.rs ? pos_r_r : pos_r_r - RW'(1);
    ocol  = cmd.cs ? pos_c_r : pos_c_r - CW'(1);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = '0;
      for (int wr = 0; wr < 3; wr++) begin
        for (int wc = 0; wc < 3; wc++) begin
          if (row_mask[wr] && col_mask[wc]) begin
            sum[k] = sum[k] + bb3_pkg::SUM_W'(win_r[wr*3+wc][k*P +: P]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      for (int k = 0; k < 3; k++) begin
        x_r[k] <= {sum[k], 1'b0} + bb3_pkg::DIVX_W'(ncell);
      end
      recip_r <= bb3_pkg::recip(rc, cc);
      orow_r  <= orow;
      ocol_r  <= ocol;
      eof_r   <= (orow == h_last) && (ocol == w_last);
      last_r  <= cmd.last;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = (bb3_pkg::DIVX_W+bb3_pkg::RECIP_W)'(x_r[k]) * recip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      for (int k = 0; k < 3; k++) begin
        q_r[k] <= prod[k][bb3_pkg::RECIP_SHIFT +: P];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_col_r  <= q_r;
      out_row_r  <= bb3_pkg::ROW_OUT_W'(orow_r);
      out_cl_r   <= bb3_pkg::COL_OUT_W'(ocol_r);
      out_last_r <= last_r;
      out_eof_r  <= eof_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {{bb3_pkg::OUT_PAD_W{1'b0}}, out_cl_r, out_row_r,
                      out_col_r[2], out_col_r[1], out_col_r[0]};
  assign out_last  = out_last_r;
  assign out_eof   = out_eof_r;

endmodule

`default_nettype wire

>>> rtl/box_blur_3x3_rgb_core.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// Streaming 3x3 box blur of an 8-bit RGB raster with border-aware rounding.
// ----------------------------------------------------------------------------
//  channel  | ports                              | beat contents
//  ---------+------------------------------------+----------------------------
//  input    | in_tvalid/in_tready/in_tdata       | one raster-order pixel
//  output   | out_tvalid/out_tready/out_tdata/   | one blurred pixel, its row
//           | out_tlast/out_tuser                | and column, run/frame marks
//  config   | cfg_we/cfg_index/cfg_wdata         | frame width, frame height
//
//  A pixel is accepted with a line buffer read, then the window is updated;
//  each result it releases passes sum, reciprocal multiply and output load.
//  The single sum/multiply unit is shared by all results.
//  Reset sets the frame to 640 x 480 and the position to the first pixel; the
//  line buffers are not cleared. Any configuration write restarts the frame.
//  A low out_tready holds the pending beat and stalls the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_rgb_core #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // in_tdata: in_red [7:0], in_green [15:8], in_blue [23:16]
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [bb3_pkg::IN_TDATA_W-1:0]   in_tdata,
  // out_tdata: out_red [7:0], out_green [15:8], out_blue [23:16],
  //            out_row [35:24], out_col [45:36], zero [47:46]
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [bb3_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  // out_tuser: end_of_frame [0]
  output logic                                  out_tuser,
  input  wire logic                             cfg_we,
  input  wire logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [bb3_pkg::FW_W-1:0] frame_width_r;
  logic [bb3_pkg::FH_W-1:0] frame_height_r;
  logic [CW-1:0]            w_last;
  logic [RW-1:0]            h_last;
  bb3_pkg::cmd_t            cmd;
  bb3_pkg::sts_t            sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= bb3_pkg::FW_W'(bb3_pkg::FRAME_WIDTH_RESET);
      frame_height_r <= bb3_pkg::FH_W'(bb3_pkg::FRAME_HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bb3_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[bb3_pkg::FW_W-1:0];
        bb3_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[bb3_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // last column and row: zero counts as one, oversize saturates
  always_comb begin
    if (frame_width_r == '0) begin
      w_last = '0;
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(frame_width_r - bb3_pkg::FW_W'(1));
    end
    if (frame_height_r == '0) begin
      h_last = '0;
    end else if (int'(frame_height_r) > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(frame_height_r - bb3_pkg::FH_W'(1));
    end
  end

  bb3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bb3_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_we),
    .w_last    (w_last),
    .h_last    (h_last),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_eof   (out_tuser)
  );

endmodule

`default_nettype wire
